// ----- hw/rtl/btgp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btgp_pkg
// Shared types and constants of the bitmap text glyph placer.
// ----------------------------------------------------------------------------
package btgp_pkg;

  // Table and coordinate sizes
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int COORD_BITS  = 16;
  localparam int OUT_BITS    = 16;

  // Character codes with fixed meaning
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] CODE_QMARK   = 8'd63;

  // Configuration register indexes
  localparam logic [2:0] REG_FIRST_CHAR    = 3'd0;
  localparam logic [2:0] REG_END_CHAR      = 3'd1;
  localparam logic [2:0] REG_SPACE_ADVANCE = 3'd2;
  localparam logic [2:0] REG_FONT_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_LINE_GAP      = 3'd4;
  localparam logic [2:0] REG_INITIAL_ROW   = 3'd5;

  // Configuration reset values
  localparam logic [7:0] FIRST_CHAR_RST    = 8'd32;
  localparam logic [8:0] END_CHAR_RST      = 9'd127;
  localparam logic [7:0] SPACE_ADVANCE_RST = 8'd4;
  localparam logic [7:0] FONT_HEIGHT_RST   = 8'd16;
  localparam logic [7:0] LINE_GAP_RST      = 8'd0;
  localparam logic [7:0] INITIAL_ROW_RST   = 8'd0;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Live configuration
  typedef struct packed {
    logic [7:0] first_char;
    logic [8:0] end_char;
    logic [7:0] space_advance;
    logic [7:0] font_height;
    logic [7:0] line_gap;
    logic [7:0] initial_row;
  } cfg_t;

  // One glyph metrics entry
  typedef struct packed {
    logic [7:0]        gw;
    logic [7:0]        gh;
    logic signed [7:0] lpad;
    logic signed [7:0] rpad;
    logic [7:0]        top;
  } entry_t;

  // Item class decided by the front
  typedef enum logic [2:0] {
    KIND_LOAD    = 3'd0,
    KIND_SPACE   = 3'd1,
    KIND_NEWLINE = 3'd2,
    KIND_GLYPH   = 3'd3,
    KIND_BAD     = 3'd4
  } kind_t;

  // Classified word carried through the queue
  typedef struct packed {
    kind_t      kind;
    logic       start;
    logic       fb;
    logic       wr_ok;
    logic [7:0] idx;
    entry_t     ent;
  } item_t;

  // One placed glyph result
  typedef struct packed {
    logic [7:0]          idx;
    logic [OUT_BITS-1:0] px;
    logic [OUT_BITS-1:0] py;
    logic                fb;
    logic                bad;
    logic [OUT_BITS-1:0] ew;
    logic [OUT_BITS-1:0] eh;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/btgp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btgp_front
// Holds configuration, accepts input words and classifies each one.
// ----------------------------------------------------------------------------
module btgp_front import btgp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // char_code, glyph_width, glyph_height,
                                       // pad_left, pad_right, top_offset
  input  wire logic [1:0]  in_tuser,   // opcode, text_start
  input  wire logic        q_full,
  output logic             q_push,
  output item_t            q_item,
  output cfg_t             cfg
);

  cfg_t       cfg_r;
  logic [7:0] code;
  logic [7:0] diff;
  logic [7:0] qdiff;

  // Code lies inside the configured table range
  function automatic logic in_tab(input logic [7:0] c, input logic [7:0] first,
                                  input logic [8:0] endc);
    logic [7:0] d;
    d = c - first;
    return (c >= first) && ({1'b0, c} < endc) && ({1'b0, d} < 9'(TABLE_DEPTH));
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_char    <= FIRST_CHAR_RST;
      cfg_r.end_char      <= END_CHAR_RST;
      cfg_r.space_advance <= SPACE_ADVANCE_RST;
      cfg_r.font_height   <= FONT_HEIGHT_RST;
      cfg_r.line_gap      <= LINE_GAP_RST;
      cfg_r.initial_row   <= INITIAL_ROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_CHAR:    cfg_r.first_char    <= cfg_wdata[7:0];
        REG_END_CHAR:      cfg_r.end_char      <= cfg_wdata;
        REG_SPACE_ADVANCE: cfg_r.space_advance <= cfg_wdata[7:0];
        REG_FONT_HEIGHT:   cfg_r.font_height   <= cfg_wdata[7:0];
        REG_LINE_GAP:      cfg_r.line_gap      <= cfg_wdata[7:0];
        REG_INITIAL_ROW:   cfg_r.initial_row   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg       = cfg_r;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  assign code  = in_tdata[7:0];
  assign diff  = code - cfg_r.first_char;
  assign qdiff = CODE_QMARK - cfg_r.first_char;

  // Classify the word
  always_comb begin
    q_item.start    = in_tuser[1];
    q_item.fb       = 1'b0;
    q_item.wr_ok    = 1'b0;
    q_item.idx      = 8'd0;
    q_item.ent.gw   = in_tdata[15:8];
    q_item.ent.gh   = in_tdata[23:16];
    q_item.ent.lpad = $signed(in_tdata[31:24]);
    q_item.ent.rpad = $signed(in_tdata[39:32]);
    q_item.ent.top  = in_tdata[47:40];
    if (in_tuser[0]) begin
      q_item.kind  = KIND_LOAD;
      q_item.idx   = code;
      q_item.wr_ok = ({1'b0, code} < 9'(TABLE_DEPTH));
    end else if (code == CODE_SPACE) begin
      q_item.kind = KIND_SPACE;
    end else if (code == CODE_NEWLINE) begin
      q_item.kind = KIND_NEWLINE;
    end else if (in_tab(code, cfg_r.first_char, cfg_r.end_char)) begin
      q_item.kind = KIND_GLYPH;
      q_item.idx  = diff;
    end else if (in_tab(CODE_QMARK, cfg_r.first_char, cfg_r.end_char)) begin
      q_item.kind = KIND_GLYPH;
      q_item.fb   = 1'b1;
      q_item.idx  = qdiff;
    end else begin
      q_item.kind = KIND_BAD;
      q_item.fb   = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/btgp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btgp_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module btgp_queue import btgp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       vld,
  output item_t      head
);

  item_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_r, wr_nxt;
  logic [QPTR_BITS-1:0] rd_r, rd_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;

  assign full = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign vld  = (cnt_r != '0);
  assign head = slot_r[rd_r];

  // Advance pointers and count
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/btgp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btgp_back
// Glyph table, cursor and extent state; places glyphs into the result register.
// ----------------------------------------------------------------------------
module btgp_back import btgp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  q_vld,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       out_vld,
  input  wire logic  out_rdy,
  output res_t       out_res
);

  localparam int SW = COORD_BITS + 3;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  entry_t                glyph_table [TABLE_DEPTH];
  entry_t                rd_r;
  item_t                 b_item_r;
  logic                  b_vld_r;
  logic                  b_res;
  logic                  b_go;
  logic                  a_go;
  logic                  out_vld_r;
  res_t                  out_res_r;
  res_t                  res;

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] mw_r, mw_nxt;
  logic [COORD_BITS-1:0] mh_r, mh_nxt;
  logic [COORD_BITS-1:0] col0, row0, mw0, mh0;
  logic [COORD_BITS-1:0] colp, py, col_gl, xe, ye, col_sp, row_nl;

  // Clamp a wide signed value to the coordinate range
  function automatic logic [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
    if (v[SW-1]) return '0;
    if (v > $signed(SW'(COORD_MAX))) return COORD_MAX;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [SW-1:0] ec(input logic [COORD_BITS-1:0] v);
    return $signed(SW'(v));
  endfunction

  function automatic logic signed [SW-1:0] e8(input logic [7:0] v);
    return $signed(SW'(v));
  endfunction

  function automatic logic signed [SW-1:0] es8(input logic signed [7:0] v);
    return SW'(v);
  endfunction

  // Handshake between read stage, place stage and result register
  assign b_res = (b_item_r.kind == KIND_GLYPH) || (b_item_r.kind == KIND_BAD);
  assign b_go  = b_vld_r && (!b_res || !out_vld_r || out_rdy);
  assign a_go  = q_vld && (!b_vld_r || b_go);
  assign q_pop = a_go;

  // Write loads, read entry for the next word
  always_ff @(posedge clk) begin
    if (a_go && (q_item.kind == KIND_LOAD) && q_item.wr_ok) begin
      glyph_table[q_item.idx[IDX_BITS-1:0]] <= q_item.ent;
    end
    if (a_go) begin
      rd_r <= glyph_table[q_item.idx[IDX_BITS-1:0]];
    end
  end

  // Hold the word in the place stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (a_go) begin
      b_vld_r <= 1'b1;
    end else if (b_go) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_item_r <= q_item;
    end
  end

  // Apply text start before the character
  assign col0 = b_item_r.start ? '0 : col_r;
  assign row0 = b_item_r.start ? COORD_BITS'(cfg.initial_row) : row_r;
  assign mw0  = b_item_r.start ? '0 : mw_r;
  assign mh0  = b_item_r.start ? '0 : mh_r;

  // Position arithmetic
  assign colp   = (col0 != '0) ? sat(ec(col0) + es8(rd_r.lpad)) : '0;
  assign py     = sat(ec(row0) + e8(rd_r.top));
  assign col_gl = sat(ec(colp) + e8(rd_r.gw) + es8(rd_r.rpad));
  assign xe     = sat(ec(colp) + e8(rd_r.gw));
  assign ye     = sat(ec(py) + e8(rd_r.gh));
  assign col_sp = sat(ec(col0) + e8(cfg.space_advance));
  assign row_nl = sat(ec(row0) + e8(cfg.font_height) + e8(cfg.line_gap));

  // Next cursor, extent and result
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    mw_nxt  = mw_r;
    mh_nxt  = mh_r;
    res.idx = b_item_r.idx;
    res.fb  = b_item_r.fb;
    res.bad = 1'b0;
    res.px  = OUT_BITS'(colp);
    res.py  = OUT_BITS'(py);
    res.ew  = OUT_BITS'(mw0);
    res.eh  = OUT_BITS'(mh0);
    unique case (b_item_r.kind)
      KIND_LOAD: ;
      KIND_SPACE: begin
        col_nxt = col_sp;
        row_nxt = row0;
        mw_nxt  = mw0;
        mh_nxt  = mh0;
      end
      KIND_NEWLINE: begin
        col_nxt = '0;
        row_nxt = row_nl;
        mw_nxt  = mw0;
        mh_nxt  = mh0;
      end
      KIND_GLYPH: begin
        col_nxt = col_gl;
        row_nxt = row0;
        mw_nxt  = (xe > mw0) ? xe : mw0;
        mh_nxt  = (ye > mh0) ? ye : mh0;
        res.ew  = OUT_BITS'(mw_nxt);
        res.eh  = OUT_BITS'(mh_nxt);
      end
      KIND_BAD: begin
        col_nxt = col0;
        row_nxt = row0;
        mw_nxt  = mw0;
        mh_nxt  = mh0;
        res.idx = 8'd0;
        res.bad = 1'b1;
        res.px  = OUT_BITS'(col0);
        res.py  = OUT_BITS'(row0);
      end
      default: ;
    endcase
  end

  // Update cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= COORD_BITS'(INITIAL_ROW_RST);
      mw_r  <= '0;
      mh_r  <= '0;
    end else if (b_go) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      mw_r  <= mw_nxt;
      mh_r  <= mh_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_go && b_res) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_res) begin
      out_res_r <= res;
    end
  end

  assign out_vld = out_vld_r;
  assign out_res = out_res_r;

endmodule
`default_nettype wire

// ----- hw/rtl/bitmap_text_glyph_placer_unit.sv -----
// An accepted word passes through the queue, then the read and place stages, then the result register.
// Throughput: one word per cycle, set by the cursor update in the back stage, while no result stalls.
// Spaces, newlines and loads give no result but still take one back stage slot each.
// Reset (rst_n low, synchronous) restores configuration, clears cursor and extents,
// and empties the queue; the glyph table is undefined until loaded, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_text_glyph_placer_unit
// Top level: classifying front, word queue and placing back.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_placer_unit import btgp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // char_code, glyph_width, glyph_height,
                                       // pad_left, pad_right, top_offset
  input  wire logic [1:0]  in_tuser,   // opcode, text_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // glyph_index, pos_x, pos_y,
                                       // extent_width, extent_height
  output logic [1:0]       out_tuser   // used_fallback, bad_glyph
);

  cfg_t  cfg;
  item_t f_item;
  item_t q_head;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_vld;
  res_t  res;

  btgp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (f_item),
    .cfg       (cfg)
  );

  btgp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .vld       (q_vld),
    .head      (q_head)
  );

  btgp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_vld   (q_vld),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .out_res (res)
  );

  // Pack the result word
  assign out_tdata = {res.eh, res.ew, res.py, res.px, res.idx};
  assign out_tuser = {res.bad, res.fb};

endmodule
`default_nettype wire

// ----- hw/rtl/btgp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btgp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module btgp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A bad glyph is always a fallback
  a_bad_fb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("bad glyph without fallback flag");

  // A bad glyph carries index zero
  a_bad_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[7:0] == 8'd0)
    else $error("bad glyph with nonzero index");

  // Drop results on reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind bitmap_text_glyph_placer_unit btgp_checker u_chk (.*);
`default_nettype wire
